[sv/ptl_pkg.sv]
// shared constants, codes and types of the popcount trie lookup
package ptl_pkg;

    localparam int DIRECT_BITS = 16;
    localparam int NODE_COUNT  = 65536;
    localparam int LEAF_COUNT  = 65536;

    localparam int DIR_SIZE = 1 << DIRECT_BITS;
    localparam int DIR_AW   = DIRECT_BITS;
    localparam int NODE_AW  = $clog2(NODE_COUNT);
    localparam int LEAF_AW  = $clog2(LEAF_COUNT);

    localparam int STRIDE   = 6;
    localparam int KEY_BITS = 128;

    localparam logic [2:0] OP_LOOKUP  = 3'd0;
    localparam logic [2:0] OP_WR_DIR  = 3'd1;
    localparam logic [2:0] OP_WR_VEC  = 3'd2;
    localparam logic [2:0] OP_WR_BASE = 3'd3;
    localparam logic [2:0] OP_WR_LEAF = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIR,
        ST_POP,
        ST_ADD,
        ST_LEAF
    } ptl_state_t;

    typedef struct packed {
        logic dir_we;
        logic vec_we;
        logic base_we;
        logic leaf_we;
    } ptl_wr_t;

    typedef struct packed {
        logic dir_re;
        logic node_re;
        logic leaf_re;
    } ptl_rd_t;

endpackage

[sv/ptl_tables.sv]
// direct, node and leaf table memories with range-checked reads
module ptl_tables (
    input  logic                          clk,
    input  ptl_pkg::ptl_wr_t              wr,
    input  logic [15:0]                   wr_index,
    input  logic [63:0]                   child_vector,
    input  logic [63:0]                   leaf_vector,
    input  logic [15:0]                   leaf_base,
    input  logic [15:0]                   child_base,
    input  logic                          direct_is_leaf,
    input  logic [15:0]                   entry_value,
    input  ptl_pkg::ptl_rd_t              rd,
    input  logic [ptl_pkg::DIR_AW-1:0]    dir_raddr,
    input  logic [15:0]                   node_raddr,
    input  logic [15:0]                   leaf_raddr,
    output logic [16:0]                   dir_rdata,
    output logic [63:0]                   node_cv,
    output logic [63:0]                   node_lv,
    output logic [15:0]                   node_lb,
    output logic [15:0]                   node_cb,
    output logic [15:0]                   leaf_rdata
);
    import ptl_pkg::*;

    logic [16:0]  dir_mem  [DIR_SIZE];
    logic [127:0] vec_mem  [NODE_COUNT];
    logic [31:0]  base_mem [NODE_COUNT];
    logic [15:0]  leaf_mem [LEAF_COUNT];

    logic [127:0] vec_q_reg;
    logic [31:0]  base_q_reg;
    logic [15:0]  leaf_q_reg;
    logic         node_ok_reg;
    logic         leaf_ok_reg;
    logic         node_ok;
    logic         leaf_ok;

    assign node_ok = {1'b0, node_raddr} < 17'(NODE_COUNT);
    assign leaf_ok = {1'b0, leaf_raddr} < 17'(LEAF_COUNT);

    always_ff @(posedge clk)
    begin
        if (wr.dir_we)
        begin
            dir_mem[wr_index[DIR_AW-1:0]] <= {direct_is_leaf, entry_value};
        end
        if (rd.dir_re)
        begin
            dir_rdata <= dir_mem[dir_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.vec_we)
        begin
            vec_mem[wr_index[NODE_AW-1:0]] <= {child_vector, leaf_vector};
        end
        if (wr.base_we)
        begin
            base_mem[wr_index[NODE_AW-1:0]] <= {leaf_base, child_base};
        end
        if (rd.node_re)
        begin
            vec_q_reg   <= vec_mem[node_raddr[NODE_AW-1:0]];
            base_q_reg  <= base_mem[node_raddr[NODE_AW-1:0]];
            node_ok_reg <= node_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.leaf_we)
        begin
            leaf_mem[wr_index[LEAF_AW-1:0]] <= entry_value;
        end
        if (rd.leaf_re)
        begin
            leaf_q_reg  <= leaf_mem[leaf_raddr[LEAF_AW-1:0]];
            leaf_ok_reg <= leaf_ok;
        end
    end

    // out of range entries read as zero
    assign node_cv    = node_ok_reg ? vec_q_reg[127:64] : '0;
    assign node_lv    = node_ok_reg ? vec_q_reg[63:0]   : '0;
    assign node_lb    = node_ok_reg ? base_q_reg[31:16] : '0;
    assign node_cb    = node_ok_reg ? base_q_reg[15:0]  : '0;
    assign leaf_rdata = leaf_ok_reg ? leaf_q_reg        : '0;

endmodule

[sv/popcount_trie_ipv6_lookup.sv]
// top level of the popcount trie longest-prefix-match lookup
//
// one command channel: an item is taken at a clock edge with start high and
// busy low. opcode selects a lookup or a write to the direct, node vector,
// node base or leaf table. writes finish in the accept cycle and never raise
// busy, so writes can be issued every cycle while no lookup holds busy. a
// lookup raises busy: the direct table read comes first, then each trie
// level has a node memory read and popcount step, then a base add step, and
// a leaf hit ends with a leaf table read. a walk has at most 18 levels. a
// walk that would need address bits past bit 128 ends early with walk_error
// high and next_hop zero.
// each lookup gives one result: done is high for one cycle with next_hop and
// walk_error, in the cycle busy drops; the receiver cannot stall it.
// reset clears the sequencer and the result strobe; table contents are
// undefined until written and no clearing pass is run.
module popcount_trie_ipv6_lookup (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [63:0] addr_hi,
    input  logic [63:0] addr_lo,
    input  logic [15:0] entry_index,
    input  logic [63:0] child_vector,
    input  logic [63:0] leaf_vector,
    input  logic [15:0] leaf_base,
    input  logic [15:0] child_base,
    input  logic        direct_is_leaf,
    input  logic [15:0] entry_value,
    output logic        done,
    output logic [15:0] next_hop,
    output logic        walk_error
);
    import ptl_pkg::*;

    ptl_state_t   state_reg, state_next;
    logic [127:0] addr_reg, addr_next;
    logic [7:0]   pos_reg, pos_next;
    logic [5:0]   bit_reg, bit_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [15:0]  base_reg, base_next;
    logic         child_reg, child_next;
    logic         done_reg, done_next;
    logic [15:0]  next_hop_reg, next_hop_next;
    logic         walk_error_reg, walk_error_next;

    ptl_wr_t      wr;
    ptl_rd_t      rd;
    logic [15:0]  node_raddr;
    logic [15:0]  leaf_raddr;
    logic [16:0]  dir_rdata;
    logic [63:0]  node_cv;
    logic [63:0]  node_lv;
    logic [15:0]  node_lb;
    logic [15:0]  node_cb;
    logic [15:0]  leaf_rdata;

    logic         accept;
    logic         take_child;
    logic         past_end;
    logic [15:0]  idx_sum;
    logic [63:0]  upto_mask;
    logic [63:0]  sel_vec;

    function automatic logic [6:0] popcnt64(input logic [63:0] v);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [6:0]  s;
        a = v - ((v >> 1) & 64'h5555555555555555);
        b = (a & 64'h3333333333333333) + ((a >> 2) & 64'h3333333333333333);
        c = (b + (b >> 4)) & 64'h0F0F0F0F0F0F0F0F;
        s = '0;
        for (int k = 0; k < 8; k++)
        begin
            s = s + 7'(c[8*k +: 4]);
        end
        return s;
    endfunction

    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign done       = done_reg;
    assign next_hop   = next_hop_reg;
    assign walk_error = walk_error_reg;

    // write decode with range checks
    always_comb
    begin
        wr.dir_we  = accept && (opcode == OP_WR_DIR)
                     && ({1'b0, entry_index} < 17'(DIR_SIZE));
        wr.vec_we  = accept && (opcode == OP_WR_VEC)
                     && ({1'b0, entry_index} < 17'(NODE_COUNT));
        wr.base_we = accept && (opcode == OP_WR_BASE)
                     && ({1'b0, entry_index} < 17'(NODE_COUNT));
        wr.leaf_we = accept && (opcode == OP_WR_LEAF)
                     && ({1'b0, entry_index} < 17'(LEAF_COUNT));
    end

    // shared popcount unit and base adder
    always_comb
    begin
        for (int k = 0; k < 64; k++)
        begin
            upto_mask[k] = (6'(k) <= bit_reg);
        end
        take_child = node_cv[bit_reg];
        sel_vec    = take_child ? node_cv : node_lv;
        idx_sum    = base_reg + 16'(cnt_reg) - 16'd1;
        past_end   = ({1'b0, pos_reg} + 9'(STRIDE)) > 9'(KEY_BITS);
    end

    ptl_tables u_tables (
        .clk            (clk),
        .wr             (wr),
        .wr_index       (entry_index),
        .child_vector   (child_vector),
        .leaf_vector    (leaf_vector),
        .leaf_base      (leaf_base),
        .child_base     (child_base),
        .direct_is_leaf (direct_is_leaf),
        .entry_value    (entry_value),
        .rd             (rd),
        .dir_raddr      (addr_hi[63 -: DIR_AW]),
        .node_raddr     (node_raddr),
        .leaf_raddr     (leaf_raddr),
        .dir_rdata      (dir_rdata),
        .node_cv        (node_cv),
        .node_lv        (node_lv),
        .node_lb        (node_lb),
        .node_cb        (node_cb),
        .leaf_rdata     (leaf_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (opcode == OP_LOOKUP))
                begin
                    state_next = ST_DIR;
                end
            end
            ST_DIR:
            begin
                state_next = dir_rdata[16] ? ST_IDLE : ST_POP;
            end
            ST_POP:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (!child_reg)
                begin
                    state_next = ST_LEAF;
                end
                else if (past_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_POP;
                end
            end
            ST_LEAF:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        addr_next       = addr_reg;
        pos_next        = pos_reg;
        bit_next        = bit_reg;
        cnt_next        = cnt_reg;
        base_next       = base_reg;
        child_next      = child_reg;
        done_next       = 1'b0;
        next_hop_next   = next_hop_reg;
        walk_error_next = walk_error_reg;
        rd              = '0;
        node_raddr      = dir_rdata[15:0];
        leaf_raddr      = idx_sum;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (opcode == OP_LOOKUP))
                begin
                    rd.dir_re = 1'b1;
                    addr_next = {addr_hi, addr_lo} << DIRECT_BITS;
                    pos_next  = 8'(DIRECT_BITS);
                end
            end
            ST_DIR:
            begin
                if (dir_rdata[16])
                begin
                    done_next       = 1'b1;
                    next_hop_next   = dir_rdata[15:0];
                    walk_error_next = 1'b0;
                end
                else
                begin
                    rd.node_re = 1'b1;
                    node_raddr = dir_rdata[15:0];
                    bit_next   = addr_reg[127 -: STRIDE];
                    addr_next  = addr_reg << STRIDE;
                    pos_next   = pos_reg + 8'(STRIDE);
                end
            end
            ST_POP:
            begin
                cnt_next   = popcnt64(sel_vec & upto_mask);
                base_next  = take_child ? node_cb : node_lb;
                child_next = take_child;
            end
            ST_ADD:
            begin
                if (!child_reg)
                begin
                    rd.leaf_re = 1'b1;
                    leaf_raddr = idx_sum;
                end
                else if (past_end)
                begin
                    done_next       = 1'b1;
                    next_hop_next   = '0;
                    walk_error_next = 1'b1;
                end
                else
                begin
                    rd.node_re = 1'b1;
                    node_raddr = idx_sum;
                    bit_next   = addr_reg[127 -: STRIDE];
                    addr_next  = addr_reg << STRIDE;
                    pos_next   = pos_reg + 8'(STRIDE);
                end
            end
            ST_LEAF:
            begin
                done_next       = 1'b1;
                next_hop_next   = leaf_rdata;
                walk_error_next = 1'b0;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        bit_reg        <= bit_next;
        cnt_reg        <= cnt_next;
        base_reg       <= base_next;
        child_reg      <= child_next;
        next_hop_reg   <= next_hop_next;
        walk_error_reg <= walk_error_next;
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a lookup is still running");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && walk_error |-> next_hop == 16'd0)
        else $error("walk error with nonzero next hop");

    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (opcode == OP_LOOKUP) |=> busy)
        else $error("lookup item accepted without going busy");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= 8'(KEY_BITS))
        else $error("walk position past the end of the address");

endmodule
